// File: hw/rtl/jhs_pkg.sv
// Package for the Jacobi heat stencil sweep: field widths, reset values,
// register indexes and the types that travel between its modules.
// No dependencies.
package jhs_pkg;

   localparam int VAL_W        = 23;          // Q7.16 temperature
   localparam int CELL_W       = VAL_W + 1;   // {locked, value}
   localparam int SUM_W        = VAL_W + 2;   // four values added
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 23;
   localparam int COLS_W       = 11;
   localparam int ROWS_W       = 15;
   localparam int ROW_CNT_W    = 14;
   localparam int MAX_ROWS     = 16384;
   localparam int DEF_MAX_COLS = 1024;

   localparam logic [VAL_W-1:0]  EPS_RESET  = VAL_W'(6554);
   localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(1024);
   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1024);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EPSILON = 2'd0,
      CSR_COLS    = 2'd1,
      CSR_ROWS    = 2'd2
   } csr_index_type;

   // Control of the accept stage as it hands its item to the window.
   typedef struct packed {
      logic fire;   // item leaves the accept stage this cycle
      logic emit;   // interior cell: gives a result
      logic last;   // final interior cell of the plate
   } a_ctl_type;

   // Stencil sums of one interior cell.
   typedef struct packed {
      logic [SUM_W-1:0] s4;
      logic [VAL_W-1:0] cv;
      logic             locked;
      logic             last;
   } sum_item_type;

endpackage

// File: hw/rtl/jacobi_heat_stencil_sweep.sv
// Top level of the Jacobi five-point heat stencil sweep: configuration,
// raster counters, accept stage. Depends on jhs_pkg and the jhs_ modules.
//
// Usage
//   req_ channel: one plate cell per item, raster order, value in unsigned
//   Q7.16 plus a locked flag. rsp_ channel: one item for every interior cell
//   (edge rows and columns give none), carrying the new value; the final
//   interior cell of a plate raises last_of_sweep, and with it not_steady
//   when the largest residual of that plate exceeded epsilon.
//   csr_ channel: index 0 epsilon, 1 cells per row, 2 rows per plate; always
//   ready. A geometry write restarts the plate at row 0, column 0. Write
//   only while no item is in flight.
//   Path: an accepted item passes the accept stage (with its line buffer
//   read), the sum register, the update register and the output register.
//   Throughput: one item per cycle while rsp_ready does not stall it, set by
//   the single read and single write per cycle on each line buffer memory.
//   Reset: counters, pipeline valids and the running maximum clear; the
//   registers return to epsilon 6554, 1024 x 1024. The line buffers need no
//   clearing: the first two rows of every plate fill them before use.
//   Stall: when rsp_ready is low the held result stays put; the stages
//   behind it keep filling, and req_ready drops only when all are full.
module jacobi_heat_stencil_sweep #(
   parameter int MAX_COLS = jhs_pkg::DEF_MAX_COLS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [jhs_pkg::VAL_W-1:0]         req_cell_value,
   input  logic                              req_cell_locked,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [jhs_pkg::VAL_W-1:0]         rsp_new_value,
   output logic                              rsp_last_of_sweep,
   output logic                              rsp_not_steady,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [jhs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jhs_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int CMP_W = (CW + 1 > jhs_pkg::COLS_W) ? CW + 1 : jhs_pkg::COLS_W;
   localparam int RW    = jhs_pkg::ROW_CNT_W;

   // Configuration registers
   logic [jhs_pkg::VAL_W-1:0]  eps_ff, eps_in;
   logic [jhs_pkg::COLS_W-1:0] cols_ff, cols_in;
   logic [jhs_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic                       restart;

   // Raster position of the next item to be accepted
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] last_col;
   logic [RW-1:0] last_row;
   logic [CMP_W-1:0] cols_ext;

   // Accept stage: waits here while its line buffer read completes
   logic                       a_valid_ff, a_valid_in;
   logic [CW-1:0]              a_col_ff, a_col_in;
   logic [jhs_pkg::CELL_W-1:0] a_cell_ff, a_cell_in;
   logic                       a_emit_ff, a_emit_in;
   logic                       a_last_ff, a_last_in;

   logic                       accept;
   logic                       b_free;
   logic                       b_valid;
   logic                       b_take;
   jhs_pkg::sum_item_type      b_item;
   jhs_pkg::a_ctl_type         a_ctl;
   logic [jhs_pkg::CELL_W-1:0] up1;
   logic [jhs_pkg::CELL_W-1:0] up2;

   assign csr_ready = 1'b1;

   // Clamp geometry to the supported range
   assign cols_ext = CMP_W'(cols_ff);
   always_comb begin
      if (cols_ext < CMP_W'(3)) begin
         last_col = CW'(2);
      end else if (cols_ext > CMP_W'(MAX_COLS)) begin
         last_col = CW'(MAX_COLS - 1);
      end else begin
         last_col = CW'(cols_ext - CMP_W'(1));
      end
      if (rows_ff < jhs_pkg::ROWS_W'(3)) begin
         last_row = RW'(2);
      end else if (rows_ff > jhs_pkg::ROWS_W'(jhs_pkg::MAX_ROWS)) begin
         last_row = RW'(jhs_pkg::MAX_ROWS - 1);
      end else begin
         last_row = RW'(rows_ff - jhs_pkg::ROWS_W'(1));
      end
   end

   // Register writes; a geometry write restarts the plate
   always_comb begin
      eps_in  = eps_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      restart = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            jhs_pkg::CSR_EPSILON: begin
               eps_in = csr_data[jhs_pkg::VAL_W-1:0];
            end
            jhs_pkg::CSR_COLS: begin
               cols_in = csr_data[jhs_pkg::COLS_W-1:0];
               restart = 1'b1;
            end
            jhs_pkg::CSR_ROWS: begin
               rows_in = csr_data[jhs_pkg::ROWS_W-1:0];
               restart = 1'b1;
            end
            default: begin
               eps_in = eps_ff;
            end
         endcase
      end
   end

   // Handshake: the accept stage frees when its item moves into the window
   assign req_ready = !a_valid_ff || b_free;
   assign accept    = req_valid && req_ready;

   assign a_ctl.fire = a_valid_ff && b_free;
   assign a_ctl.emit = a_emit_ff;
   assign a_ctl.last = a_last_ff;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      a_valid_in = a_valid_ff;
      a_col_in   = a_col_ff;
      a_cell_in  = a_cell_ff;
      a_emit_in  = a_emit_ff;
      a_last_in  = a_last_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_col_in   = col_ff;
         a_cell_in  = {req_cell_locked, req_cell_value};
         a_emit_in  = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
         a_last_in  = (row_ff == last_row) && (col_ff == last_col);
         // advance the raster position, wrapping at row and plate end
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (a_ctl.fire) begin
         a_valid_in = 1'b0;
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff     <= jhs_pkg::EPS_RESET;
         cols_ff    <= jhs_pkg::COLS_RESET;
         rows_ff    <= jhs_pkg::ROWS_RESET;
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         eps_ff     <= eps_in;
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
      a_col_ff  <= a_col_in;
      a_cell_ff <= a_cell_in;
      a_emit_ff <= a_emit_in;
      a_last_ff <= a_last_in;
   end

   // Read at accept, write back when the item leaves the accept stage. The
   // same entry is touched again only a full row (three items at least) later.
   jhs_line_store #(
      .MAX_COLS (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (a_ctl.fire),
      .wr_addr (a_col_ff),
      .wr_cell (a_cell_ff),
      .up1     (up1),
      .up2     (up2)
   );

   jhs_window u_window (
      .clock   (clock),
      .reset   (reset),
      .a_ctl   (a_ctl),
      .a_cell  (a_cell_ff),
      .up1     (up1),
      .up2     (up2),
      .b_take  (b_take),
      .b_free  (b_free),
      .b_valid (b_valid),
      .b_item  (b_item)
   );

   jhs_update u_update (
      .clock             (clock),
      .reset             (reset),
      .epsilon           (eps_ff),
      .clear_max         (restart),
      .b_valid           (b_valid),
      .b_item            (b_item),
      .b_take            (b_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_new_value     (rsp_new_value),
      .rsp_last_of_sweep (rsp_last_of_sweep),
      .rsp_not_steady    (rsp_not_steady)
   );

   // Steady flag only ever rides on the last result of a plate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_not_steady || rsp_last_of_sweep))
      else $error("not_steady raised on a result that is not last");

   // A held item in the accept stage is never lost while the window is full
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_free) |=> a_valid_ff)
      else $error("accept stage item dropped under stall");

   // Every accepted item occupies the accept stage on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> a_valid_ff)
      else $error("accepted item missing from accept stage");

   // Only interior columns give a result
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_emit_ff) |-> (a_col_ff >= CW'(2)))
      else $error("result flagged for an edge column");

endmodule

// File: hw/rtl/jhs_line_store.sv
// Two line buffers of the stencil, one synchronous memory per plate row.
// Depends on jhs_pkg.
module jhs_line_store #(
   parameter int MAX_COLS = jhs_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_COLS)-1:0]     rd_addr,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_COLS)-1:0]     wr_addr,
   input  logic [jhs_pkg::CELL_W-1:0]      wr_cell,
   output logic [jhs_pkg::CELL_W-1:0]      up1,
   output logic [jhs_pkg::CELL_W-1:0]      up2
);

   logic [jhs_pkg::CELL_W-1:0] line1_mem [MAX_COLS];
   logic [jhs_pkg::CELL_W-1:0] line2_mem [MAX_COLS];
   logic [jhs_pkg::CELL_W-1:0] up1_ff;
   logic [jhs_pkg::CELL_W-1:0] up2_ff;

   // Read data holds until the next read; the row above moves down a line.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         up1_ff <= line1_mem[rd_addr];
         up2_ff <= line2_mem[rd_addr];
      end
      if (wr_en) begin
         line1_mem[wr_addr] <= wr_cell;
         line2_mem[wr_addr] <= up1_ff;
      end
   end

   assign up1 = up1_ff;
   assign up2 = up2_ff;

endmodule

// File: hw/rtl/jhs_window.sv
// Stencil window registers and the sum stage of the heat sweep.
// Depends on jhs_pkg.
module jhs_window (
   input  logic                         clock,
   input  logic                         reset,
   input  jhs_pkg::a_ctl_type           a_ctl,
   input  logic [jhs_pkg::CELL_W-1:0]   a_cell,
   input  logic [jhs_pkg::CELL_W-1:0]   up1,
   input  logic [jhs_pkg::CELL_W-1:0]   up2,
   input  logic                         b_take,
   output logic                         b_free,
   output logic                         b_valid,
   output jhs_pkg::sum_item_type        b_item
);

   // Only four window places feed the next stencil: north, west, centre, south.
   logic [jhs_pkg::VAL_W-1:0]  w_north_ff, w_north_in;
   logic [jhs_pkg::VAL_W-1:0]  w_west_ff,  w_west_in;
   logic [jhs_pkg::CELL_W-1:0] w_ctr_ff,   w_ctr_in;
   logic [jhs_pkg::VAL_W-1:0]  w_south_ff, w_south_in;
   logic                       b_valid_ff, b_valid_in;
   jhs_pkg::sum_item_type      b_item_ff,  b_item_in;

   always_comb begin
      w_north_in = w_north_ff;
      w_west_in  = w_west_ff;
      w_ctr_in   = w_ctr_ff;
      w_south_in = w_south_ff;
      b_valid_in = b_valid_ff;
      b_item_in  = b_item_ff;
      if (a_ctl.fire) begin
         w_north_in = up2[jhs_pkg::VAL_W-1:0];
         w_west_in  = w_ctr_ff[jhs_pkg::VAL_W-1:0];
         w_ctr_in   = up1;
         w_south_in = a_cell[jhs_pkg::VAL_W-1:0];
         b_valid_in = a_ctl.emit;
         // After the shift: N = old north, S = old south, W = old west,
         // E = row above just read, centre = old centre.
         b_item_in.s4 = jhs_pkg::SUM_W'(w_north_ff) + jhs_pkg::SUM_W'(w_south_ff)
                      + jhs_pkg::SUM_W'(w_west_ff)
                      + jhs_pkg::SUM_W'(up1[jhs_pkg::VAL_W-1:0]);
         b_item_in.cv     = w_ctr_ff[jhs_pkg::VAL_W-1:0];
         b_item_in.locked = w_ctr_ff[jhs_pkg::VAL_W];
         b_item_in.last   = a_ctl.last;
      end else if (b_take) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_north_ff <= '0;
         w_west_ff  <= '0;
         w_ctr_ff   <= '0;
         w_south_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         w_north_ff <= w_north_in;
         w_west_ff  <= w_west_in;
         w_ctr_ff   <= w_ctr_in;
         w_south_ff <= w_south_in;
         b_valid_ff <= b_valid_in;
      end
      b_item_ff <= b_item_in;
   end

   assign b_free  = !b_valid_ff || b_take;
   assign b_valid = b_valid_ff;
   assign b_item  = b_item_ff;

endmodule

// File: hw/rtl/jhs_update.sv
// Update stage of the heat sweep: new value, residual, running maximum and
// the result register. Depends on jhs_pkg.
module jhs_update (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [jhs_pkg::VAL_W-1:0]    epsilon,
   input  logic                         clear_max,
   input  logic                         b_valid,
   input  jhs_pkg::sum_item_type        b_item,
   output logic                         b_take,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [jhs_pkg::VAL_W-1:0]    rsp_new_value,
   output logic                         rsp_last_of_sweep,
   output logic                         rsp_not_steady
);

   localparam int W = jhs_pkg::VAL_W;

   logic           c_valid_ff, c_valid_in;
   logic [W-1:0]   c_nv_ff, c_nv_in;
   logic [W-1:0]   c_res_ff, c_res_in;
   logic           c_locked_ff, c_locked_in;
   logic           c_last_ff, c_last_in;
   logic [W-1:0]   max_ff, max_in;
   logic           out_valid_ff, out_valid_in;
   logic [W-1:0]   out_value_ff, out_value_in;
   logic           out_last_ff, out_last_in;
   logic           out_ns_ff, out_ns_in;
   logic           out_free;
   logic           c_take;
   logic [jhs_pkg::SUM_W-1:0] c4;
   logic [jhs_pkg::SUM_W:0]   total;
   logic [jhs_pkg::SUM_W-1:0] diff;
   logic [W-1:0]   cand;

   assign out_free = !out_valid_ff || rsp_ready;
   assign c_take   = out_free;
   assign b_take   = !c_valid_ff || c_take;

   always_comb begin
      c4    = {b_item.cv, 2'b00};
      total = (jhs_pkg::SUM_W+1)'(b_item.s4) + (jhs_pkg::SUM_W+1)'(c4);
      diff  = (c4 >= b_item.s4) ? (c4 - b_item.s4) : (b_item.s4 - c4);

      c_valid_in  = c_valid_ff;
      c_nv_in     = c_nv_ff;
      c_res_in    = c_res_ff;
      c_locked_in = c_locked_ff;
      c_last_in   = c_last_ff;
      if (b_take) begin
         c_valid_in  = b_valid;
         c_nv_in     = b_item.locked ? b_item.cv : total[W+2:3];
         c_res_in    = diff[W+1:2];
         c_locked_in = b_item.locked;
         c_last_in   = b_item.last;
      end

      cand = (!c_locked_ff && (c_res_ff > max_ff)) ? c_res_ff : max_ff;

      max_in       = max_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ns_in    = out_ns_ff;
      if (out_free) begin
         out_valid_in = c_valid_ff;
      end
      if (c_valid_ff && c_take) begin
         out_value_in = c_nv_ff;
         out_last_in  = c_last_ff;
         out_ns_in    = c_last_ff && (cand > epsilon);
         // drop the maximum once the plate is done
         max_in       = c_last_ff ? '0 : cand;
      end
      if (clear_max) begin
         max_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
      c_nv_ff      <= c_nv_in;
      c_res_ff     <= c_res_in;
      c_locked_ff  <= c_locked_in;
      c_last_ff    <= c_last_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ns_ff    <= out_ns_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_new_value     = out_value_ff;
   assign rsp_last_of_sweep = out_last_ff;
   assign rsp_not_steady    = out_ns_ff;

endmodule
